// File: rtl/ogrm_pkg.sv
// Shared types and constants for the occupancy grid ray marker.
// No dependencies; used by ogrm_line_walk, the top level and the testbench.
package ogrm_pkg;

    localparam int OFS_W     = 9;   // hit offset width
    localparam int DW        = 10;  // line delta width
    localparam int EW        = 11;  // line error width
    localparam int CFG_W     = 8;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_SCAN  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
    localparam logic [1:0] CELL_FREE     = 2'd1;
    localparam logic [1:0] CELL_OCCUPIED = 2'd2;

    localparam logic CFG_SCANNER_X = 1'b0;
    localparam logic CFG_SCANNER_Y = 1'b1;

    typedef struct packed {
        logic busy;
        logic wr_free;
    } walk_status_t;

endpackage

// File: rtl/ogrm_grid_mem.sv
// Grid cell store: one write port, one read port, registered read data.
// Depends on nothing but its parameter.
module ogrm_grid_mem #(
    parameter int AW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [1:0]    rdata
);

    logic [1:0] mem [2**AW];
    logic [1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/ogrm_line_walk.sv
// Bresenham line walker: one cell per cycle from start point to end point.
// Depends on ogrm_pkg.
module ogrm_line_walk #(
    parameter int CW = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [CW-1:0]  x0,
    input  logic signed [CW-1:0]  y0,
    input  logic signed [CW-1:0]  x1,
    input  logic signed [CW-1:0]  y1,
    output logic signed [CW-1:0]  wx,
    output logic signed [CW-1:0]  wy,
    output ogrm_pkg::walk_status_t st
);

    localparam int E2W = ogrm_pkg::EW + 1;

    logic                           busy_reg;
    logic signed [CW-1:0]           walk_x_reg, walk_x_next;
    logic signed [CW-1:0]           walk_y_reg, walk_y_next;
    logic signed [ogrm_pkg::EW-1:0] line_error_reg, line_error_next;
    logic signed [CW-1:0]           x1_reg, y1_reg;
    logic [ogrm_pkg::DW-1:0]        dx_reg, dy_reg;
    logic                           sx_neg_reg, sy_neg_reg;

    logic [CW-1:0]                  dx_full, dy_full;
    logic [ogrm_pkg::DW-1:0]        dx0, dy0;
    logic signed [ogrm_pkg::DW:0]   err0;
    logic signed [E2W-1:0]          e2, ndy, pdx, err_sum;
    logic                           step_x, step_y, at_end;

    always_comb
    begin
        dx_full = (x1 > x0) ? CW'(x1 - x0) : CW'(x0 - x1);
        dy_full = (y1 > y0) ? CW'(y1 - y0) : CW'(y0 - y1);
        dx0     = ogrm_pkg::DW'(dx_full);
        dy0     = ogrm_pkg::DW'(dy_full);
        err0    = $signed({1'b0, dx0}) - $signed({1'b0, dy0});

        at_end  = (walk_x_reg == x1_reg) && (walk_y_reg == y1_reg);
        e2      = {line_error_reg, 1'b0};
        ndy     = -$signed(E2W'(dy_reg));
        pdx     = $signed(E2W'(dx_reg));
        step_x  = e2 > ndy;
        step_y  = e2 < pdx;
        err_sum = E2W'(line_error_reg) + (step_x ? ndy : '0) + (step_y ? pdx : '0);
        line_error_next = ogrm_pkg::EW'(err_sum);

        walk_x_next = walk_x_reg;
        if (step_x)
        begin
            walk_x_next = sx_neg_reg ? walk_x_reg - CW'(1) : walk_x_reg + CW'(1);
        end
        walk_y_next = walk_y_reg;
        if (step_y)
        begin
            walk_y_next = sy_neg_reg ? walk_y_reg - CW'(1) : walk_y_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            walk_x_reg     <= '0;
            walk_y_reg     <= '0;
            line_error_reg <= '0;
            x1_reg         <= '0;
            y1_reg         <= '0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            sx_neg_reg     <= 1'b0;
            sy_neg_reg     <= 1'b0;
        end
        else if (start)
        begin
            busy_reg       <= 1'b1;
            walk_x_reg     <= x0;
            walk_y_reg     <= y0;
            line_error_reg <= ogrm_pkg::EW'(err0);
            x1_reg         <= x1;
            y1_reg         <= y1;
            dx_reg         <= dx0;
            dy_reg         <= dy0;
            sx_neg_reg     <= !(x0 < x1);
            sy_neg_reg     <= !(y0 < y1);
        end
        else if (busy_reg)
        begin
            if (at_end)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                walk_x_reg     <= walk_x_next;
                walk_y_reg     <= walk_y_next;
                line_error_reg <= line_error_next;
            end
        end
    end

    assign wx         = walk_x_reg;
    assign wy         = walk_y_reg;
    assign st.busy    = busy_reg;
    assign st.wr_free = busy_reg && !at_end;

endmodule

// File: rtl/occupancy_grid_ray_marker_unit.sv
// Top level of the occupancy grid ray marker: control, config and stream ports.
// Depends on ogrm_pkg, ogrm_grid_mem and ogrm_line_walk.
//
// Usage:
// - s_* carries requests: s_tuser holds the mode (clear, scan point, read cell),
//   s_tdata the hit offsets and read coordinates. One request is worked at a time.
// - m_* returns one result per request: status (point skipped) and cell class.
// - cfg_we/cfg_index/cfg_wdata set the scanner cell; write only while idle.
// Request flow (every request ends in ST_DONE, which loads the result register):
// - Read: the memory read is registered at accept; ST_READ captures the cell class.
//   Ignored mode and skipped scan point: straight to ST_DONE.
// - Scan point: ST_MARK marks the hit cell occupied, then the line walker writes
//   L = max(|dx|, |dy|) <= 255 free cells, one per cycle, via the single write port.
// - Clear: writes all 2**(clog2(GRID_COLUMNS)+clog2(GRID_ROWS)) cells, one per cycle.
// Reset: the same clearing pass runs after reset; s_tready stays low until done
// (65536 cells at the default size).
// Stall: a result waits in the output register; the next request is accepted
// meanwhile, and its own result waits until the register is free.
module occupancy_grid_ray_marker_unit #(
    parameter int GRID_COLUMNS = 256,
    parameter int GRID_ROWS    = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // hit_offset_x, hit_offset_y, read_x, read_y, zero fill
    input  logic [ogrm_pkg::S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, cell_class, zero fill
    output logic [ogrm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [ogrm_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int XW = $clog2(GRID_COLUMNS);
    localparam int YW = $clog2(GRID_ROWS);
    localparam int AW = XW + YW;
    localparam int MXY = (XW > YW) ? XW : YW;
    localparam int MW = (MXY > 9) ? MXY : 9;
    localparam int CW = MW + 2;
    localparam logic [CW-1:0] COLS_U = CW'(GRID_COLUMNS);
    localparam logic [CW-1:0] ROWS_U = CW'(GRID_ROWS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_WALK,
        ST_READ,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [AW-1:0]              clr_cnt_reg;
    logic                       reply_clr_reg;
    logic                       res_status_reg;
    logic [1:0]                 res_class_reg;
    logic                       rd_ok_reg;
    logic signed [CW-1:0]       hx_reg, hy_reg;
    logic [ogrm_pkg::CFG_W-1:0] scanner_x_reg, scanner_y_reg;
    logic                       m_tvalid_reg;
    logic                       m_status_reg;
    logic [1:0]                 m_class_reg;

    ogrm_pkg::mode_t               mode;
    logic signed [ogrm_pkg::OFS_W-1:0] off_x, off_y;
    logic [7:0]                    read_x, read_y;
    logic signed [CW-1:0]          hx, hy, sxc, syc, wx, wy;
    logic                          hit_ok, rd_ok, wr_ok, accept;
    ogrm_pkg::walk_status_t        walk_st;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [1:0]    mem_wdata, mem_rdata;

    assign mode   = ogrm_pkg::mode_t'(s_tuser);
    assign off_x  = $signed(s_tdata[8:0]);
    assign off_y  = $signed(s_tdata[17:9]);
    assign read_x = s_tdata[25:18];
    assign read_y = s_tdata[33:26];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign sxc = CW'($signed({1'b0, scanner_x_reg}));
    assign syc = CW'($signed({1'b0, scanner_y_reg}));
    assign hx  = sxc + CW'(off_x);
    assign hy  = syc + CW'(off_y);

    assign hit_ok = !hx[CW-1] && !hy[CW-1]
                    && ($unsigned(hx) < COLS_U) && ($unsigned(hy) < ROWS_U);
    assign rd_ok  = (CW'(read_x) < COLS_U) && (CW'(read_y) < ROWS_U);
    assign wr_ok  = !wx[CW-1] && !wy[CW-1]
                    && ($unsigned(wx) < COLS_U) && ($unsigned(wy) < ROWS_U);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = ogrm_pkg::CELL_UNKNOWN;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_MARK:
            begin
                mem_we    = 1'b1;
                mem_waddr = {YW'(hy_reg), XW'(hx_reg)};
                mem_wdata = ogrm_pkg::CELL_OCCUPIED;
            end
            ST_WALK:
            begin
                mem_we    = walk_st.wr_free && wr_ok;
                mem_waddr = {YW'(wy), XW'(wx)};
                mem_wdata = ogrm_pkg::CELL_FREE;
            end
            ST_IDLE, ST_READ, ST_DONE:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_re    = accept && (mode == ogrm_pkg::MODE_READ);
    assign mem_raddr = {YW'(read_y), XW'(read_x)};

    ogrm_grid_mem #(
        .AW (AW)
    ) u_grid_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ogrm_line_walk #(
        .CW (CW)
    ) u_line_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_MARK),
        .x0    (sxc),
        .y0    (syc),
        .x1    (hx_reg),
        .y1    (hy_reg),
        .wx    (wx),
        .wy    (wy),
        .st    (walk_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanner_x_reg <= ogrm_pkg::CFG_W'(128);
            scanner_y_reg <= ogrm_pkg::CFG_W'(128);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ogrm_pkg::CFG_SCANNER_X: scanner_x_reg <= cfg_wdata;
                ogrm_pkg::CFG_SCANNER_Y: scanner_y_reg <= cfg_wdata;
                default:                 scanner_x_reg <= scanner_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            reply_clr_reg  <= 1'b0;
            res_status_reg <= 1'b0;
            res_class_reg  <= ogrm_pkg::CELL_UNKNOWN;
            rd_ok_reg      <= 1'b0;
            hx_reg         <= '0;
            hy_reg         <= '0;
            m_tvalid_reg   <= 1'b0;
            m_status_reg   <= 1'b0;
            m_class_reg    <= ogrm_pkg::CELL_UNKNOWN;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == '1)
                    begin
                        state_reg <= reply_clr_reg ? ST_DONE : ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_status_reg <= (mode == ogrm_pkg::MODE_SCAN) && !hit_ok;
                        res_class_reg  <= ogrm_pkg::CELL_UNKNOWN;
                        hx_reg         <= hx;
                        hy_reg         <= hy;
                        rd_ok_reg      <= rd_ok;
                        unique case (mode)
                            ogrm_pkg::MODE_CLEAR:
                            begin
                                clr_cnt_reg   <= '0;
                                reply_clr_reg <= 1'b1;
                                state_reg     <= ST_CLEAR;
                            end
                            ogrm_pkg::MODE_SCAN:
                            begin
                                if (hit_ok)
                                begin
                                    state_reg <= ST_MARK;
                                end
                                else
                                begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            ogrm_pkg::MODE_READ: state_reg <= ST_READ;
                            ogrm_pkg::MODE_NONE: state_reg <= ST_DONE;
                            default:             state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_MARK:
                begin
                    state_reg <= ST_WALK;
                end
                ST_WALK:
                begin
                    if (!walk_st.busy)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_READ:
                begin
                    res_class_reg <= rd_ok_reg ? mem_rdata : ogrm_pkg::CELL_UNKNOWN;
                    state_reg     <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_class_reg  <= res_class_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_class_reg, m_status_reg};

endmodule

// File: dv/testbench.sv
// Testbench for occupancy_grid_ray_marker_unit: a directed request table, then random
// phases per scanner cell; checked vs typed rows or a grid/line-walk predictor.
// Depends on rtl/ogrm_pkg.sv and rtl/occupancy_grid_ray_marker_unit.sv.
`timescale 1ns / 100ps

module testbench;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int PHASE_ITEMS    = 150;
    localparam int DIR_ROWS       = 21;

    typedef struct packed {
        logic       status;
        logic [1:0] cell_class;
    } cell_result_t;

    typedef struct packed {
        ogrm_pkg::mode_t mode;
        logic [8:0]      ofs_x;
        logic [8:0]      ofs_y;
        logic [7:0]      rd_x;
        logic [7:0]      rd_y;
        logic            fixed;
        logic            status;
        logic [1:0]      cell_class;
    } dir_row_t;

    // fixed = 1: expected result typed here, otherwise taken from the predictor
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{ogrm_pkg::MODE_READ,  9'd0,     9'd0,     8'd0,   8'd0,   1'b1, 1'b0,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_READ,  9'd0,     9'd0,     8'd255, 8'd255, 1'b1, 1'b0,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_SCAN,  9'd0,     9'd0,     8'd0,   8'd0,   1'b0, 1'b0,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_READ,  9'd0,     9'd0,     8'd128, 8'd128, 1'b1, 1'b0,
          ogrm_pkg::CELL_OCCUPIED},
        '{ogrm_pkg::MODE_SCAN,  9'd127,   9'd127,   8'd0,   8'd0,   1'b0, 1'b0,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_READ,  9'd0,     9'd0,     8'd255, 8'd255, 1'b1, 1'b0,
          ogrm_pkg::CELL_OCCUPIED},
        '{ogrm_pkg::MODE_READ,  9'd0,     9'd0,     8'd254, 8'd254, 1'b0, 1'b0,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_SCAN,  -9'sd128, -9'sd128, 8'd0,   8'd0,   1'b0, 1'b0,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_READ,  9'd0,     9'd0,     8'd0,   8'd0,   1'b0, 1'b0,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_SCAN,  9'd128,   9'd0,     8'd0,   8'd0,   1'b1, 1'b1,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_SCAN,  -9'sd129, 9'd0,     8'd0,   8'd0,   1'b1, 1'b1,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_SCAN,  9'd255,   9'd255,   8'd0,   8'd0,   1'b1, 1'b1,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_SCAN,  -9'sd255, -9'sd255, 8'd0,   8'd0,   1'b1, 1'b1,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_SCAN,  9'd0,     -9'sd129, 8'd0,   8'd0,   1'b1, 1'b1,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_SCAN,  9'd127,   -9'sd128, 8'd0,   8'd0,   1'b0, 1'b0,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_SCAN,  -9'sd3,   9'd100,   8'd0,   8'd0,   1'b0, 1'b0,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_READ,  9'd0,     9'd0,     8'd128, 8'd200, 1'b0, 1'b0,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_NONE,  9'h1FF,   9'h1FF,   8'd255, 8'd255, 1'b1, 1'b0,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_CLEAR, 9'd0,     9'd0,     8'd0,   8'd0,   1'b1, 1'b0,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_READ,  9'd0,     9'd0,     8'd128, 8'd128, 1'b1, 1'b0,
          ogrm_pkg::CELL_UNKNOWN},
        '{ogrm_pkg::MODE_READ,  9'd0,     9'd0,     8'd255, 8'd0,   1'b1, 1'b0,
          ogrm_pkg::CELL_UNKNOWN}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [ogrm_pkg::S_TDATA_W-1:0] s_tdata;
    logic [1:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [ogrm_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           cfg_we;
    logic                           cfg_index;
    logic [ogrm_pkg::CFG_W-1:0]     cfg_wdata;

    // predictor state
    logic [1:0]   grid [65536];
    logic [7:0]   scan_x;
    logic [7:0]   scan_y;
    int           trace_err;
    int           trace_x;
    int           trace_y;

    cell_result_t expected_q [$];
    int           mismatches;
    int           quiet_cycles;
    bit           steady;
    bit           hold_req;
    int           last_hx;
    int           last_hy;

    occupancy_grid_ray_marker_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic cell_result_t grid_predict(ogrm_pkg::mode_t m, logic [8:0] ofs_x,
                                                  logic [8:0] ofs_y, logic [7:0] rd_x,
                                                  logic [7:0] rd_y);
        cell_result_t r;
        int           hx;
        int           hy;
        int           dx;
        int           dy;
        int           sx;
        int           sy;
        int           e2;
        r = '0;
        case (m)
            ogrm_pkg::MODE_CLEAR:
            begin
                foreach (grid[i])
                    grid[i] = ogrm_pkg::CELL_UNKNOWN;
            end
            ogrm_pkg::MODE_SCAN:
            begin
                hx = int'(scan_x) + int'($signed(ofs_x));
                hy = int'(scan_y) + int'($signed(ofs_y));
                if (hx < 0 || hy < 0 || hx > 255 || hy > 255)
                    r.status = 1'b1;
                else
                begin
                    grid[{hy[7:0], hx[7:0]}] = ogrm_pkg::CELL_OCCUPIED;
                    dx = (hx > scan_x) ? hx - int'(scan_x) : int'(scan_x) - hx;
                    dy = (hy > scan_y) ? hy - int'(scan_y) : int'(scan_y) - hy;
                    sx = (int'(scan_x) < hx) ? 1 : -1;
                    sy = (int'(scan_y) < hy) ? 1 : -1;
                    trace_err = dx - dy;
                    trace_x   = scan_x;
                    trace_y   = scan_y;
                    while (!(trace_x == hx && trace_y == hy))
                    begin
                        grid[{trace_y[7:0], trace_x[7:0]}] = ogrm_pkg::CELL_FREE;
                        e2 = 2 * trace_err;
                        if (e2 > -dy)
                        begin
                            trace_err -= dy;
                            trace_x   += sx;
                        end
                        if (e2 < dx)
                        begin
                            trace_err += dx;
                            trace_y   += sy;
                        end
                    end
                end
            end
            ogrm_pkg::MODE_READ:
                r.cell_class = grid[{rd_y, rd_x}];
            default: ;
        endcase
        return r;
    endfunction

    task automatic write_scanner(logic idx, logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == ogrm_pkg::CFG_SCANNER_X)
            scan_x = val;
        else
            scan_y = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(ogrm_pkg::mode_t m, logic [8:0] ofs_x, logic [8:0] ofs_y,
                                logic [7:0] rd_x, logic [7:0] rd_y, logic fixed,
                                cell_result_t fixed_res);
        cell_result_t res;
        @(negedge clk);
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= {6'd0, rd_y, rd_x, ofs_y, ofs_x};
        do
            @(posedge clk);
        while (!s_tready);
        res = grid_predict(m, ofs_x, ofs_y, rd_x, rd_y);
        expected_q.push_back(fixed ? fixed_res : res);
    endtask

    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int n, bit with_clear);
        int              pick;
        ogrm_pkg::mode_t m;
        logic [8:0]      ofs_x;
        logic [8:0]      ofs_y;
        logic [7:0]      rd_x;
        logic [7:0]      rd_y;
        if (with_clear)
            send_request(ogrm_pkg::MODE_CLEAR, 9'($urandom), 9'($urandom), 8'($urandom),
                         8'($urandom), 1'b0, '0);
        for (int i = 0; i < n; i++)
        begin
            pick  = $urandom_range(0, 99);
            ofs_x = 9'($urandom);
            ofs_y = 9'($urandom);
            rd_x  = 8'($urandom);
            rd_y  = 8'($urandom);
            if (pick < 55)
            begin
                m = ogrm_pkg::MODE_SCAN;
                if ($urandom_range(0, 1) == 0)
                begin
                    ofs_x = 9'($urandom_range(0, 40) - 20);
                    ofs_y = 9'($urandom_range(0, 40) - 20);
                end
                else
                begin
                    ofs_x = 9'($urandom_range(0, 510) - 255);
                    ofs_y = 9'($urandom_range(0, 510) - 255);
                end
                last_hx = int'(scan_x) + int'($signed(ofs_x));
                last_hy = int'(scan_y) + int'($signed(ofs_y));
            end
            else if (pick < 95)
            begin
                m = ogrm_pkg::MODE_READ;
                // aim most reads at the last ray: its hit cell or its midpoint
                case ($urandom_range(0, 2))
                    0:
                    begin
                        rd_x = 8'(last_hx);
                        rd_y = 8'(last_hy);
                    end
                    1:
                    begin
                        rd_x = 8'((last_hx + int'(scan_x)) / 2);
                        rd_y = 8'((last_hy + int'(scan_y)) / 2);
                    end
                    default: ;
                endcase
            end
            else
                m = ogrm_pkg::MODE_NONE;
            send_request(m, ofs_x, ofs_y, rd_x, rd_y, 1'b0, '0);
        end
        drain();
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!steady && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL occupancy_grid_ray_marker_unit");
            $finish;
        end
        if (m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no request pending: m_tdata %0h", m_tdata);
                mismatches++;
            end
            else
            begin
                if (m_tdata[0] !== expected_q[0].status)
                begin
                    $error("status expected %0d got %0d", expected_q[0].status, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[2:1] !== expected_q[0].cell_class)
                begin
                    $error("cell_class expected %0d got %0d", expected_q[0].cell_class,
                           m_tdata[2:1]);
                    mismatches++;
                end
                void'(expected_q.pop_front());
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ogrm_pkg::MODE_CLEAR;
        cfg_we       = 1'b0;
        cfg_index    = ogrm_pkg::CFG_SCANNER_X;
        cfg_wdata    = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        steady       = 1'b0;
        hold_req     = 1'b0;
        scan_x       = 8'd128;
        scan_y       = 8'd128;
        trace_err    = 0;
        trace_x      = 0;
        trace_y      = 0;
        last_hx      = 128;
        last_hy      = 128;
        foreach (grid[i])
            grid[i] = ogrm_pkg::CELL_UNKNOWN;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_request(DIR_TAB[i].mode, DIR_TAB[i].ofs_x, DIR_TAB[i].ofs_y,
                         DIR_TAB[i].rd_x, DIR_TAB[i].rd_y, DIR_TAB[i].fixed,
                         '{DIR_TAB[i].status, DIR_TAB[i].cell_class});
        drain();

        write_scanner(ogrm_pkg::CFG_SCANNER_X, 8'd0);
        write_scanner(ogrm_pkg::CFG_SCANNER_Y, 8'd0);
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS, 1'b0);

        write_scanner(ogrm_pkg::CFG_SCANNER_X, 8'd255);
        write_scanner(ogrm_pkg::CFG_SCANNER_Y, 8'd255);
        run_phase(PHASE_ITEMS, 1'b0);

        write_scanner(ogrm_pkg::CFG_SCANNER_X, 8'd0);
        write_scanner(ogrm_pkg::CFG_SCANNER_Y, 8'd255);
        run_phase(PHASE_ITEMS, 1'b1);

        write_scanner(ogrm_pkg::CFG_SCANNER_X, 8'd255);
        write_scanner(ogrm_pkg::CFG_SCANNER_Y, 8'd0);
        run_phase(PHASE_ITEMS, 1'b0);

        write_scanner(ogrm_pkg::CFG_SCANNER_X, 8'($urandom));
        write_scanner(ogrm_pkg::CFG_SCANNER_Y, 8'($urandom));
        run_phase(PHASE_ITEMS, 1'b1);

        steady = 1'b1;
        write_scanner(ogrm_pkg::CFG_SCANNER_X, 8'($urandom));
        write_scanner(ogrm_pkg::CFG_SCANNER_Y, 8'($urandom));
        run_phase(PHASE_ITEMS, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS occupancy_grid_ray_marker_unit");
        else
            $display("FAIL occupancy_grid_ray_marker_unit");
        $finish;
    end

endmodule
